// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the camera pointing RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/ctp_pkg.sv =====
// Types, widths and CORDIC constants for the camera pointing pipeline.
package ctp_pkg;
   localparam int ANGLE_BITS   = 16;
   localparam int POS_BITS     = 32;
   localparam int CORDIC_STEPS = 31;
   localparam int TRIG_FRAC    = 14;
   localparam int ROT_W        = 34;
   localparam int TRIG_W       = TRIG_FRAC + 3;
   localparam int PROD_W       = POS_BITS + TRIG_W;
   localparam int OFF_W        = PROD_W + 2;
   localparam int VEC_W        = OFF_W + 2;
   localparam int ZW           = 34;
   localparam int HGT_W        = POS_BITS + 1;
   localparam int SC_LAT       = CORDIC_STEPS + 2;
   localparam int AT_LAT       = CORDIC_STEPS + 2;

   localparam logic signed [ROT_W-1:0] GAIN_INV = ROT_W'(32'd652032874);

   typedef struct packed {
      logic adv;
      logic vld;
   } step_ctl_type;

   typedef struct packed {
      logic                         mode;
      logic signed [POS_BITS-1:0]   tx;
      logic signed [POS_BITS-1:0]   ty;
      logic signed [POS_BITS-1:0]   vx;
      logic signed [POS_BITS-1:0]   vy;
      logic signed [HGT_W-1:0]      hgt;
      logic signed [ANGLE_BITS-1:0] roll;
      logic signed [ANGLE_BITS-1:0] pitch;
   } side_type;

   typedef struct packed {
      logic                         mode;
      logic signed [ANGLE_BITS-1:0] roll;
      logic signed [ANGLE_BITS-1:0] pitch;
   } att_type;

   // atan(2^-i) on a 32-bit binary angle
   function automatic logic signed [ZW-1:0] atan_step(input int idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'd536870912;  1: v = 32'd316933406;  2: v = 32'd167458907;
         3: v = 32'd85004756;   4: v = 32'd42667331;   5: v = 32'd21354465;
         6: v = 32'd10679838;   7: v = 32'd5340245;    8: v = 32'd2670163;
         9: v = 32'd1335087;   10: v = 32'd667544;    11: v = 32'd333772;
        12: v = 32'd166886;    13: v = 32'd83443;     14: v = 32'd41722;
        15: v = 32'd20861;     16: v = 32'd10430;     17: v = 32'd5215;
        18: v = 32'd2608;      19: v = 32'd1304;      20: v = 32'd652;
        21: v = 32'd326;       22: v = 32'd163;       23: v = 32'd81;
        24: v = 32'd41;        25: v = 32'd20;        26: v = 32'd10;
        27: v = 32'd5;         28: v = 32'd3;         29: v = 32'd1;
        30: v = 32'd1;
        default: v = 32'd0;
      endcase
      return ZW'(v);
   endfunction
endpackage

// ===== rtl/core/ctp_sincos.sv =====
// Pipelined rotation CORDIC: cosine and sine of the heading in Q.14.
module ctp_sincos (
   input  logic                                clock,
   input  logic                                reset,
   input  ctp_pkg::step_ctl_type               ctl,
   input  logic signed [ctp_pkg::ANGLE_BITS-1:0] heading,
   output logic                                vld,
   output logic signed [ctp_pkg::TRIG_W-1:0]   cos_q,
   output logic signed [ctp_pkg::TRIG_W-1:0]   sin_q
);
   import ctp_pkg::*;

   localparam logic signed [ROT_W-1:0] QUARTER = ROT_W'(1) <<< 30;
   localparam logic signed [ROT_W-1:0] HALF    = ROT_W'(1) <<< 31;
   localparam logic signed [ROT_W-1:0] RND     = ROT_W'(1) <<< (29 - TRIG_FRAC);

   logic signed [ROT_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [ROT_W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [ROT_W-1:0] a_ff [0:CORDIC_STEPS];
   logic                    neg_ff [0:CORDIC_STEPS];
   logic                    v_ff [0:CORDIC_STEPS];
   logic                    vo_ff;
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;

   logic signed [31:0]      ang32;
   logic signed [ROT_W-1:0] a_wide, a_red;
   logic                    neg_in;
   logic signed [ROT_W-1:0] xr, yr;

   assign ang32 = {heading, {(32 - ANGLE_BITS){1'b0}}};

   // fold the angle into +-pi/2 and remember the sign flip
   always_comb begin
      a_wide = ROT_W'(ang32);
      a_red  = a_wide;
      neg_in = 1'b0;
      if (a_wide > QUARTER) begin
         a_red  = a_wide - HALF;
         neg_in = 1'b1;
      end else if (a_wide < -QUARTER) begin
         a_red  = a_wide + HALF;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) v_ff[k] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (ctl.adv) begin
         v_ff[0] <= ctl.vld;
         for (int k = 0; k < CORDIC_STEPS; k++) v_ff[k+1] <= v_ff[k];
         vo_ff <= v_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         x_ff[0]   <= GAIN_INV;
         y_ff[0]   <= '0;
         a_ff[0]   <= a_red;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
      logic signed [ROT_W-1:0] dx, dy;
      assign dx = y_ff[g] >>> g;
      assign dy = x_ff[g] >>> g;
      always_ff @(posedge clock) begin
         if (ctl.adv) begin
            if (a_ff[g] >= 0) begin
               x_ff[g+1] <= x_ff[g] - dx;
               y_ff[g+1] <= y_ff[g] + dy;
               a_ff[g+1] <= a_ff[g] - atan_step(g);
            end else begin
               x_ff[g+1] <= x_ff[g] + dx;
               y_ff[g+1] <= y_ff[g] - dy;
               a_ff[g+1] <= a_ff[g] + atan_step(g);
            end
            neg_ff[g+1] <= neg_ff[g];
         end
      end
   end

   assign xr = (x_ff[CORDIC_STEPS] + RND) >>> (30 - TRIG_FRAC);
   assign yr = (y_ff[CORDIC_STEPS] + RND) >>> (30 - TRIG_FRAC);

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         cos_ff <= neg_ff[CORDIC_STEPS] ? TRIG_W'(-xr) : TRIG_W'(xr);
         sin_ff <= neg_ff[CORDIC_STEPS] ? TRIG_W'(-yr) : TRIG_W'(yr);
      end
   end

   assign vld   = vo_ff;
   assign cos_q = cos_ff;
   assign sin_q = sin_ff;
endmodule

// ===== rtl/core/ctp_atan.sv =====
// Pipelined vectoring CORDIC: atan(offset / height) as a binary angle.
module ctp_atan (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ctp_pkg::step_ctl_type                ctl,
   input  logic signed [ctp_pkg::OFF_W-1:0]     offset,
   input  logic signed [ctp_pkg::HGT_W-1:0]     hgt,
   output logic                                 vld,
   output logic signed [ctp_pkg::ANGLE_BITS-1:0] ang,
   output logic                                 hz
);
   import ctp_pkg::*;

   localparam logic signed [ZW-1:0] ZRND = ZW'(1) <<< (31 - ANGLE_BITS);
   localparam logic signed [ANGLE_BITS-1:0] R90 = ANGLE_BITS'(1) <<< (ANGLE_BITS - 2);

   logic signed [VEC_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [ZW-1:0]    z_ff [0:CORDIC_STEPS];
   logic                    flip_ff [0:CORDIC_STEPS];
   logic                    hz_ff [0:CORDIC_STEPS];
   logic                    nneg_ff [0:CORDIC_STEPS];
   logic                    v_ff [0:CORDIC_STEPS];
   logic                    vo_ff, hzo_ff;
   logic signed [ANGLE_BITS-1:0] ang_ff;

   logic signed [OFF_W-1:0]      an;
   logic signed [HGT_W-1:0]      ah;
   logic signed [ZW-1:0]         zr;
   logic signed [ANGLE_BITS-1:0] r;

   assign an = offset[OFF_W-1] ? -offset : offset;
   assign ah = hgt[HGT_W-1] ? -hgt : hgt;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) v_ff[k] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (ctl.adv) begin
         v_ff[0] <= ctl.vld;
         for (int k = 0; k < CORDIC_STEPS; k++) v_ff[k+1] <= v_ff[k];
         vo_ff <= v_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         x_ff[0]    <= VEC_W'(ah) <<< TRIG_FRAC;
         y_ff[0]    <= VEC_W'(an);
         z_ff[0]    <= '0;
         flip_ff[0] <= offset[OFF_W-1] != hgt[HGT_W-1];
         hz_ff[0]   <= hgt == '0;
         nneg_ff[0] <= offset[OFF_W-1];
      end
   end

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
      logic signed [VEC_W-1:0] dx, dy;
      assign dx = y_ff[g] >>> g;
      assign dy = x_ff[g] >>> g;
      always_ff @(posedge clock) begin
         if (ctl.adv) begin
            if (y_ff[g] >= 0) begin
               x_ff[g+1] <= x_ff[g] + dx;
               y_ff[g+1] <= y_ff[g] - dy;
               z_ff[g+1] <= z_ff[g] + atan_step(g);
            end else begin
               x_ff[g+1] <= x_ff[g] - dx;
               y_ff[g+1] <= y_ff[g] + dy;
               z_ff[g+1] <= z_ff[g] - atan_step(g);
            end
            flip_ff[g+1] <= flip_ff[g];
            hz_ff[g+1]   <= hz_ff[g];
            nneg_ff[g+1] <= nneg_ff[g];
         end
      end
   end

   assign zr = (z_ff[CORDIC_STEPS] + ZRND) >>> (32 - ANGLE_BITS);
   assign r  = zr[ANGLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         hzo_ff <= hz_ff[CORDIC_STEPS];
         // saturate to +-pi/2 on zero height
         if (hz_ff[CORDIC_STEPS]) ang_ff <= nneg_ff[CORDIC_STEPS] ? -R90 : R90;
         else                     ang_ff <= flip_ff[CORDIC_STEPS] ? -r : r;
      end
   end

   assign vld = vo_ff;
   assign ang = ang_ff;
   assign hz  = hzo_ff;
endmodule

// ===== rtl/core/camera_target_pointing_core.sv =====
// Top level: camera gimbal roll and pitch from vehicle pose and a ground target.
//
//   channel   | direction | handshake          | payload
//   req_      | in        | req_valid/ready    | mode, target, vehicle position/attitude
//   rsp_      | out       | rsp_valid/ready    | camera_roll, camera_pitch, height_zero
//   csr_      | in        | csr_wr_en          | ground_altitude
//
// One request per cycle while the output register is free or being taken; the path runs
// through the heading CORDIC, a multiply, a sum, the arctangent CORDIC and the output register.
// Synchronous reset clears all valid bits and sets ground_altitude to zero.
// A full output register that is not taken holds the whole pipeline in place.
`include "assert_macros.svh"
module camera_target_pointing_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic signed [ctp_pkg::POS_BITS-1:0]   req_target_east,
   input  logic signed [ctp_pkg::POS_BITS-1:0]   req_target_north,
   input  logic signed [ctp_pkg::POS_BITS-1:0]   req_vehicle_x,
   input  logic signed [ctp_pkg::POS_BITS-1:0]   req_vehicle_y,
   input  logic signed [ctp_pkg::POS_BITS-1:0]   req_vehicle_z,
   input  logic signed [ctp_pkg::ANGLE_BITS-1:0] req_vehicle_roll,
   input  logic signed [ctp_pkg::ANGLE_BITS-1:0] req_vehicle_pitch,
   input  logic signed [ctp_pkg::ANGLE_BITS-1:0] req_vehicle_heading,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [ctp_pkg::ANGLE_BITS-1:0] rsp_camera_roll,
   output logic signed [ctp_pkg::ANGLE_BITS-1:0] rsp_camera_pitch,
   output logic                                  rsp_height_zero,
   input  logic                                  csr_wr_en,
   input  logic signed [ctp_pkg::POS_BITS-1:0]   csr_wr_data
);
   import ctp_pkg::*;

   logic signed [POS_BITS-1:0] ground_alt_ff;
   logic adv;
   step_ctl_type sc_ctl, at_ctl;

   side_type side_ff [0:SC_LAT-1];
   side_type side1_ff, side2_ff;
   att_type  att_ff [0:AT_LAT-1];

   logic sc_vld;
   logic signed [TRIG_W-1:0] cos_q, sin_q;
   logic v1_ff, v2_ff;
   logic signed [PROD_W-1:0] tc_ff, ts_ff, txs_ff, tyc_ff;
   logic signed [OFF_W-1:0]  nx_ff, ny_ff;

   logic ax_vld, ay_vld, ax_hz, ay_hz;
   logic signed [ANGLE_BITS-1:0] ax_ang, ay_ang;

   logic rsp_valid_ff, hz_out_ff;
   logic signed [ANGLE_BITS-1:0] roll_out_ff, pitch_out_ff;
   att_type att_o;
   logic hz_take;

   // advance whenever the output register is free or being taken
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign sc_ctl    = '{adv: adv, vld: req_valid};
   assign at_ctl    = '{adv: adv, vld: v2_ff};

   always_ff @(posedge clock) begin
      if (reset) ground_alt_ff <= '0;
      else if (csr_wr_en) ground_alt_ff <= csr_wr_data;
   end

   ctp_sincos u_sincos (
      .clock(clock), .reset(reset), .ctl(sc_ctl), .heading(req_vehicle_heading),
      .vld(sc_vld), .cos_q(cos_q), .sin_q(sin_q)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0].mode  <= req_mode;
         side_ff[0].tx    <= req_target_east;
         side_ff[0].ty    <= req_target_north;
         side_ff[0].vx    <= req_vehicle_x;
         side_ff[0].vy    <= req_vehicle_y;
         side_ff[0].hgt   <= HGT_W'(req_vehicle_z) - HGT_W'(ground_alt_ff);
         side_ff[0].roll  <= req_vehicle_roll;
         side_ff[0].pitch <= req_vehicle_pitch;
         for (int k = 1; k < SC_LAT; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= sc_vld;
         v2_ff <= v1_ff;
      end
   end

   // rotate the target by the heading and subtract the vehicle position
   always_ff @(posedge clock) begin
      if (adv) begin
         tc_ff    <= PROD_W'(side_ff[SC_LAT-1].tx) * PROD_W'(cos_q);
         ts_ff    <= PROD_W'(side_ff[SC_LAT-1].ty) * PROD_W'(sin_q);
         txs_ff   <= PROD_W'(side_ff[SC_LAT-1].tx) * PROD_W'(sin_q);
         tyc_ff   <= PROD_W'(side_ff[SC_LAT-1].ty) * PROD_W'(cos_q);
         side1_ff <= side_ff[SC_LAT-1];
         nx_ff    <= OFF_W'(tc_ff) - OFF_W'(ts_ff) - (OFF_W'(side1_ff.vx) <<< TRIG_FRAC);
         ny_ff    <= OFF_W'(txs_ff) + OFF_W'(tyc_ff) - (OFF_W'(side1_ff.vy) <<< TRIG_FRAC);
         side2_ff <= side1_ff;
      end
   end

   ctp_atan u_atan_x (
      .clock(clock), .reset(reset), .ctl(at_ctl), .offset(nx_ff), .hgt(side2_ff.hgt),
      .vld(ax_vld), .ang(ax_ang), .hz(ax_hz)
   );

   ctp_atan u_atan_y (
      .clock(clock), .reset(reset), .ctl(at_ctl), .offset(ny_ff), .hgt(side2_ff.hgt),
      .vld(ay_vld), .ang(ay_ang), .hz(ay_hz)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         att_ff[0] <= '{mode: side2_ff.mode, roll: side2_ff.roll, pitch: side2_ff.pitch};
         for (int k = 1; k < AT_LAT; k++) att_ff[k] <= att_ff[k-1];
      end
   end

   assign att_o = att_ff[AT_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ax_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_out_ff  <= att_o.mode ? ax_ang - att_o.roll  : -att_o.roll;
         pitch_out_ff <= att_o.mode ? ay_ang - att_o.pitch : -att_o.pitch;
         hz_out_ff    <= att_o.mode & ax_hz;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_camera_roll  = roll_out_ff;
   assign rsp_camera_pitch = pitch_out_ff;
   assign rsp_height_zero  = hz_out_ff;

   assign hz_take = adv && ax_vld && att_o.mode && ax_hz;

   `AST_IMPL(a_lane_valid, clock, reset, 1'b1, ax_vld == ay_vld)
   `AST_IMPL(a_lane_hz, clock, reset, ax_vld, ax_hz == ay_hz)
   `AST_NEXT(a_hz_out, clock, reset, hz_take, rsp_valid && rsp_height_zero)
endmodule
